// ----- src/pps_pkg.sv -----
package pps_pkg;

  localparam int TIME_W    = 20;
  localparam int METRIC_W  = 21;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  task_id;
    logic [15:0] arrival_time;
    logic [15:0] burst_length;
    logic [7:0]  priority_level;
  } pps_in_t;

  typedef struct packed {
    logic                ran_valid;
    logic [7:0]          ran_id;
    logic                finished;
    logic [METRIC_W-1:0] turnaround_time;
    logic [METRIC_W-1:0] waiting_time;
    logic                all_done;
    logic                load_rejected;
  } pps_out_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [15:0] remaining;
  } pps_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_UPDATE,
    ST_RESULT
  } pps_state_t;

  typedef struct packed {
    logic latch_item;
    logic do_load;
    logic do_clear;
    logic scan_start;
    logic scan_run;
    logic do_update;
    logic out_load;
  } pps_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       scan_done;
    logic       out_free;
  } pps_stat_t;

endpackage

// ----- src/pps_ram.sv -----
module pps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/pps_ctrl.sv -----
module pps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pps_pkg::pps_stat_t stat,
  output pps_pkg::pps_cmd_t  cmd
);

  import pps_pkg::*;

  pps_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = !rst_n || (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && rst_n) begin
          cmd.latch_item = 1'b1;
          state_nxt      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (stat.command)
          CMD_LOAD: begin
            cmd.do_load = 1'b1;
            state_nxt   = ST_RESULT;
          end
          CMD_TICK: begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end
          CMD_CLEAR: begin
            cmd.do_clear = 1'b1;
            state_nxt    = ST_RESULT;
          end
          default: begin
            state_nxt = ST_RESULT;
          end
        endcase
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.do_update = 1'b1;
        state_nxt     = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/pps_datapath.sv -----
module pps_datapath #(
  parameter int MAX_TASKS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pps_pkg::pps_in_t   in_data,
  input  pps_pkg::pps_cmd_t  cmd,
  output pps_pkg::pps_stat_t stat,
  input  logic               out_stall,
  output logic               out_valid,
  output pps_pkg::pps_out_t  out_data
);

  import pps_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TASKS);

  pps_in_t           item_r;
  pps_out_t          res_r;
  pps_out_t          res_final;
  pps_out_t          out_data_r;
  logic              out_valid_r;
  logic [CNT_W-1:0]  loaded_cnt_r;
  logic [CNT_W-1:0]  done_cnt_r;
  logic [TIME_W-1:0] current_time_r;

  logic [CNT_W-1:0]  scan_idx_r;
  logic [IDX_W-1:0]  pend_idx_r;
  logic              pend_r;
  logic              found_r;
  logic [IDX_W-1:0]  best_idx_r;
  pps_entry_t        best_r;

  pps_entry_t        rd_entry;
  pps_entry_t        wr_entry;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic              issue;
  logic              load_ok;
  logic              ready;
  logic              better;
  logic [15:0]       rem_dec;
  logic [METRIC_W-1:0] turn;
  logic [METRIC_W-1:0] burst_ext;
  logic [METRIC_W-1:0] wait_t;

  assign issue   = cmd.scan_run && (scan_idx_r < loaded_cnt_r);
  assign load_ok = (loaded_cnt_r < MAX_CNT) && (item_r.burst_length != 16'd0);
  assign ready   = ({{(TIME_W-16){1'b0}}, rd_entry.arrival} <= current_time_r) &&
                   (rd_entry.remaining != 16'd0);
  assign better  = ready && (!found_r || (rd_entry.prio < best_r.prio));

  assign rem_dec   = best_r.remaining - 16'd1;
  assign turn      = {1'b0, current_time_r} + METRIC_W'(1) -
                     {{(METRIC_W-16){1'b0}}, best_r.arrival};
  assign burst_ext = {{(METRIC_W-16){1'b0}}, best_r.burst};
  assign wait_t    = (turn >= burst_ext) ? (turn - burst_ext) : '0;

  always_comb begin
    wr_entry  = best_r;
    ram_waddr = best_idx_r;
    wr_entry.remaining = rem_dec;
    if (cmd.do_load) begin
      ram_waddr          = loaded_cnt_r[IDX_W-1:0];
      wr_entry.id        = item_r.task_id;
      wr_entry.arrival   = item_r.arrival_time;
      wr_entry.burst     = item_r.burst_length;
      wr_entry.prio      = item_r.priority_level;
      wr_entry.remaining = item_r.burst_length;
    end
  end

  assign ram_we = (cmd.do_load && load_ok) || (cmd.do_update && found_r);

  pps_ram #(
    .WIDTH ($bits(pps_entry_t)),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (scan_idx_r[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_r <= in_data;
    end
    if (cmd.scan_run && pend_r && better) begin
      best_r     <= rd_entry;
      best_idx_r <= pend_idx_r;
    end
    if (cmd.scan_run) begin
      pend_idx_r <= scan_idx_r[IDX_W-1:0];
    end
  end

  // Table bookkeeping, time and scan control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_cnt_r   <= '0;
      done_cnt_r     <= '0;
      current_time_r <= '0;
      scan_idx_r     <= '0;
      pend_r         <= 1'b0;
      found_r        <= 1'b0;
      res_r          <= '0;
    end else begin
      if (cmd.latch_item) begin
        res_r <= '0;
      end
      if (cmd.do_load) begin
        if (load_ok) begin
          loaded_cnt_r <= loaded_cnt_r + CNT_W'(1);
        end else begin
          res_r.load_rejected <= 1'b1;
        end
      end
      if (cmd.do_clear) begin
        loaded_cnt_r   <= '0;
        done_cnt_r     <= '0;
        current_time_r <= '0;
      end
      if (cmd.scan_start) begin
        scan_idx_r <= '0;
        pend_r     <= 1'b0;
        found_r    <= 1'b0;
      end else if (cmd.scan_run) begin
        pend_r <= issue;
        if (issue) begin
          scan_idx_r <= scan_idx_r + CNT_W'(1);
        end
        if (pend_r && better) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.do_update) begin
        if (current_time_r != TIME_MAX) begin
          current_time_r <= current_time_r + TIME_W'(1);
        end
        if (found_r) begin
          res_r.ran_valid <= 1'b1;
          res_r.ran_id    <= best_r.id;
          if (rem_dec == 16'd0) begin
            res_r.finished        <= 1'b1;
            res_r.turnaround_time <= turn;
            res_r.waiting_time    <= wait_t;
            done_cnt_r            <= done_cnt_r + CNT_W'(1);
          end
        end
      end
    end
  end

  // Completion status is sampled after the command took effect.
  always_comb begin
    res_final          = res_r;
    res_final.all_done = (done_cnt_r == loaded_cnt_r);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= res_final;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign stat.command   = item_r.command;
  assign stat.scan_done = !pend_r && (scan_idx_r == loaded_cnt_r);
  assign stat.out_free  = !out_valid_r || !out_stall;

  a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_cnt_r <= MAX_CNT) else $error("task count exceeds table size");

  a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_cnt_r <= loaded_cnt_r) else $error("more tasks completed than loaded");

  a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_update |=> (current_time_r == $past(current_time_r) + TIME_W'(1)) ||
                      (current_time_r == TIME_MAX))
    else $error("tick did not advance time");

  a_finish_ran: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.finished |-> out_data_r.ran_valid)
    else $error("completion reported without a running task");

endmodule

// ----- src/preemptive_priority_scheduler.sv -----
// Preemptive priority scheduler with a table of up to MAX_TASKS tasks.
// The input channel (in_valid, in_stall, in_data) carries one command item:
// load a task entry, advance one tick, clear the table and time, or do nothing.
// The result channel (out_valid, out_stall, out_data) returns exactly one item
// for every command item, in order.
// A tick reads the task table one entry per cycle from a RAM with separate
// read and write ports and a registered read. The table scan over the RAM
// read port makes a tick take longer than a load, clear or no-op.
// One command is worked on at a time; the next item is accepted in the cycle
// after the previous result is loaded into the output register, even while
// that is stalled, so no item is taken while the last is still in work.
// When the receiver holds out_stall, the result stays in the output register
// and the block stops before loading the next result.
// Reset empties the table, clears the completion count and sets time to zero;
// the input stalls while reset is held. Table contents need no clearing
// because only loaded entries are ever read.
module preemptive_priority_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pps_pkg::pps_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pps_pkg::pps_out_t out_data
);

  import pps_pkg::*;

  // Command strobes from the sequencer and status back from the datapath.
  pps_cmd_t  cmd;
  pps_stat_t stat;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the task table, the counters, the best-candidate
  // registers of the scan and the output register.
  pps_datapath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- test/preemptive_priority_scheduler_tb.sv -----
module preemptive_priority_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pps_pkg::*;

  localparam int TABLE_DEPTH = 16;
  // Rough number of command items in the whole run; no-ops are not counted.
  localparam int ITEM_TARGET = 500;
  // The last items of the run go through with neither side idling.
  localparam int CALM_TAIL = 80;
  // A tick with a full table is the longest command, and both sides may add
  // idling on top of that. Anything far beyond this is a hang.
  localparam int HANG_LIMIT = 2000;
  // Cycles to wait after the last expected result, so that a stray extra
  // result would still be seen.
  localparam int SETTLE_CYCLES = 50;

  // Scoreboard: a model of the task table and clock that works out the
  // result of every accepted command, plus the queue of results that the
  // block still owes.
  class sched_scoreboard;
    pps_entry_t        task_table [TABLE_DEPTH];
    int unsigned       loaded_tasks;
    int unsigned       completed_tasks;
    logic [TIME_W-1:0] sched_clock = '0;
    pps_out_t          owed_reports [$];
    int unsigned       mismatches;

    function void note_command(pps_in_t item);
      pps_out_t            report;
      int                  best;
      logic [METRIC_W-1:0] span;
      report = '0;
      case (item.command)
        CMD_LOAD: begin
          if (loaded_tasks >= TABLE_DEPTH || item.burst_length == 16'd0) begin
            report.load_rejected = 1'b1;
          end else begin
            task_table[loaded_tasks].id        = item.task_id;
            task_table[loaded_tasks].arrival   = item.arrival_time;
            task_table[loaded_tasks].burst     = item.burst_length;
            task_table[loaded_tasks].prio      = item.priority_level;
            task_table[loaded_tasks].remaining = item.burst_length;
            loaded_tasks++;
          end
        end
        CMD_TICK: begin
          // Lowest priority value among ready tasks; strict compare keeps
          // the lower table index on a tie.
          best = -1;
          for (int i = 0; i < loaded_tasks; i++) begin
            if (task_table[i].arrival <= sched_clock && task_table[i].remaining != 16'd0) begin
              if (best < 0 || task_table[i].prio < task_table[best].prio) begin
                best = i;
              end
            end
          end
          if (best >= 0) begin
            report.ran_valid = 1'b1;
            report.ran_id    = task_table[best].id;
            task_table[best].remaining = task_table[best].remaining - 16'd1;
            if (task_table[best].remaining == 16'd0) begin
              span = METRIC_W'(sched_clock + 1 - task_table[best].arrival);
              report.finished        = 1'b1;
              report.turnaround_time = span;
              report.waiting_time    = (span >= task_table[best].burst) ?
                                       span - task_table[best].burst : '0;
              completed_tasks++;
            end
          end
          if (sched_clock != TIME_MAX) begin
            sched_clock++;
          end
        end
        CMD_CLEAR: begin
          loaded_tasks    = 0;
          completed_tasks = 0;
          sched_clock     = '0;
        end
        default: begin
        end
      endcase
      report.all_done = (completed_tasks == loaded_tasks);
      owed_reports.push_back(report);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(pps_out_t got);
      pps_out_t want;
      if (owed_reports.size() == 0) begin
        $error("result arrived with no command outstanding");
        mismatches++;
        return;
      end
      want = owed_reports.pop_front();
      compare_field("ran_valid", want.ran_valid, got.ran_valid);
      compare_field("ran_id", want.ran_id, got.ran_id);
      compare_field("finished", want.finished, got.finished);
      compare_field("turnaround_time", want.turnaround_time, got.turnaround_time);
      compare_field("waiting_time", want.waiting_time, got.waiting_time);
      compare_field("all_done", want.all_done, got.all_done);
      compare_field("load_rejected", want.load_rejected, got.load_rejected);
    endfunction

    function int unsigned outstanding();
      return owed_reports.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  pps_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pps_out_t out_data;

  sched_scoreboard sb = new();
  int unsigned     items_sent = 0;
  bit              calm = 1'b0;

  preemptive_priority_scheduler #(
    .MAX_TASKS(TABLE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Both monitors sample at the rising edge. All testbench drives are
  // nonblocking, so the values seen here are the ones the block saw.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_command(in_data);
    end
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
    end
  end

  // The receiver stalls in random bursts, with runs of free flow in between,
  // and stops stalling in the calm tail of the run.
  initial begin
    forever begin
      @(posedge clk);
      if (calm || $urandom_range(0, 4) != 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run if no item moves on either channel for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic pps_in_t make_item(logic [1:0] command, logic [7:0] task_id,
                                        logic [15:0] arrival, logic [15:0] burst,
                                        logic [7:0] prio);
    pps_in_t item;
    item.command        = command;
    item.task_id        = task_id;
    item.arrival_time   = arrival;
    item.burst_length   = burst;
    item.priority_level = prio;
    return item;
  endfunction

  // Offers one item and returns at the edge where it is accepted. Valid
  // stays high across back-to-back items; an idle burst drops it first.
  // Called at a rising edge.
  task automatic send_item(input pps_in_t item);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (item.command != CMD_NOP) begin
      items_sent++;
    end
  endtask

  // Holds off the sender until the block has returned every result owed.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Any command with fully random fields, including no-ops and loads with
  // huge or zero bursts and far-off arrivals.
  task automatic send_noise();
    send_item(make_item(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                        16'($urandom), 8'($urandom)));
  endtask

  // A well-formed workload: clear, load a batch of short tasks that arrive
  // early, then tick until they have most likely finished. Priorities are
  // often drawn from a narrow range so that ties and preemption are common.
  // Stray noise items are mixed in now and then, and sometimes the tick
  // run is cut short.
  task automatic run_workload();
    int unsigned n_tasks;
    int unsigned work;
    int unsigned n_ticks;
    logic [15:0] burst;
    logic [7:0]  prio;
    n_tasks = ($urandom_range(0, 3) == 0) ? $urandom_range(9, TABLE_DEPTH) :
                                             $urandom_range(1, 6);
    work = 0;
    send_item(make_item(CMD_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom),
                        8'($urandom)));
    for (int i = 0; i < n_tasks; i++) begin
      burst = 16'($urandom_range(1, 5));
      prio  = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      work += burst;
      send_item(make_item(CMD_LOAD, 8'($urandom), 16'($urandom_range(0, 12)), burst,
                          prio));
    end
    n_ticks = ($urandom_range(0, 5) == 0) ? $urandom_range(1, work) :
                                             work + $urandom_range(0, 14);
    for (int i = 0; i < n_ticks; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_noise();
      end
      send_item(make_item(CMD_TICK, 8'($urandom), 16'($urandom), 16'($urandom),
                          8'($urandom)));
    end
  endtask

  initial begin
    bit paused_mid;
    paused_mid = 1'b0;

    // Synchronous reset.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. An empty table ticks idle and reports all done; a
    // no-op with every field bit set changes nothing; a zero-burst load is
    // refused.
    send_item(make_item(CMD_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00));
    send_item(make_item(CMD_NOP, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_item(make_item(CMD_LOAD, 8'h11, 16'h0000, 16'h0000, 8'h00));
    // Clock now reads 1. The second task arrives at 1 with top priority and
    // finishes first. The first and third tie at the lowest priority, so the
    // lower index runs to completion before the third. The fourth never
    // arrives, which leaves a final idle tick with all_done low.
    send_item(make_item(CMD_LOAD, 8'hFF, 16'h0000, 16'h0002, 8'hFF));
    send_item(make_item(CMD_LOAD, 8'h00, 16'h0001, 16'h0001, 8'h00));
    send_item(make_item(CMD_LOAD, 8'hA5, 16'h0000, 16'h0001, 8'hFF));
    send_item(make_item(CMD_LOAD, 8'h5A, 16'hFFFF, 16'hFFFF, 8'h00));
    repeat (5) begin
      send_item(make_item(CMD_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00));
    end
    // Fill the table to the top, then one load more is refused as full.
    for (int i = 4; i <= TABLE_DEPTH; i++) begin
      send_item(make_item(CMD_LOAD, 8'(i), 16'(i), 16'(i), 8'(i)));
    end
    send_item(make_item(CMD_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00));
    send_item(make_item(CMD_CLEAR, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF));

    // The sender waits for the block to catch up completely here, and once
    // more halfway through the random part.
    drain_results();

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= ITEM_TARGET - CALM_TAIL) begin
        calm = 1'b1;
      end
      if (!paused_mid && items_sent >= ITEM_TARGET / 2) begin
        paused_mid = 1'b1;
        drain_results();
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) send_noise();
      end else begin
        run_workload();
      end
    end
    in_valid <= 1'b0;

    // Wait for every owed result, then a while longer for strays.
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
